/* rtl/core/sfa_pkg.sv */
// Shared types and constants of the sparse fragmented array table.
`default_nettype none
package sfa_pkg;

  localparam int unsigned IdxW   = 13;
  localparam int unsigned CountW = 7;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned CfgW   = 32;

  typedef enum logic [2:0] {
    OP_SET = 3'd0,
    OP_GET = 3'd1,
    OP_DEL = 3'd2,
    OP_HAS = 3'd3,
    OP_CLR = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_IDX = 2'd1,
    ST_NO_DEL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_FRAGS  = 2'd0,
    CFG_CELLS  = 2'd1,
    CFG_MARKER = 2'd2
  } cfg_e;

  typedef struct packed {
    logic [2:0]               opcode;
    logic [IdxW-1:0]          cell_index;
    logic signed [KeyW-1:0]   key_value;
  } in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [KeyW-1:0]   read_value;
    logic                     key_found;
    logic [IdxW-1:0]          used_cells;
    logic [CountW-1:0]        live_fragments;
  } out_t;

  // Classified command passed from front to back.
  typedef struct packed {
    op_e                op;
    logic               idx_ok;
    logic [IdxW-1:0]    frag;
    logic [CountW-1:0]  off;
    logic [KeyW-1:0]    key;
  } cmd_t;

endpackage
`default_nettype wire

/* rtl/core/sfa_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none
module sfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/core/sfa_front.sv */
// Front end: accepts transactions, checks the index and splits it by serial division.
`default_nettype none
module sfa_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output      logic            in_stall_o,
  input  wire sfa_pkg::in_t    in_i,
  input  wire logic [6:0]      nf_i,
  input  wire logic [6:0]      nc_i,
  output      logic            push_valid_o,
  input  wire logic            push_ready_i,
  output      sfa_pkg::cmd_t   push_cmd_o
);
  import sfa_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_e;

  fstate_e           state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [IdxW-1:0]   quo_q, quo_d;
  logic [6:0]        rem_q, rem_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [13:0]       cap;
  logic              ok;
  logic [7:0]        rem_sh;
  logic              take;

  assign cap    = 14'(nf_i * nc_i);
  assign ok     = (nc_i != 7'd0) && ({1'b0, in_i.cell_index} < cap);
  assign rem_sh = {rem_q, quo_q[IdxW-1]};
  assign take   = rem_sh >= {1'b0, nc_i};

  assign in_stall_o   = (state_q != F_IDLE);
  assign push_valid_o = (state_q == F_PUSH);
  assign push_cmd_o   = cmd_q;

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          cmd_d.op     = op_e'(in_i.opcode);
          cmd_d.idx_ok = ok;
          cmd_d.frag   = '0;
          cmd_d.off    = '0;
          cmd_d.key    = in_i.key_value;
          quo_d        = in_i.cell_index;
          rem_d        = '0;
          cnt_d        = 4'(IdxW - 1);
          if (ok && (in_i.opcode inside {OP_SET, OP_GET, OP_DEL})) begin
            state_d = F_DIV;
          end else begin
            state_d = F_PUSH;
          end
        end
      end
      F_DIV: begin
        // one quotient bit per cycle, MSB first
        rem_d = take ? 7'(rem_sh - {1'b0, nc_i}) : rem_sh[6:0];
        quo_d = {quo_q[IdxW-2:0], take};
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          cmd_d.frag = {quo_q[IdxW-2:0], take};
          cmd_d.off  = take ? 7'(rem_sh - {1'b0, nc_i}) : rem_sh[6:0];
          state_d    = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
  end

endmodule
`default_nettype wire

/* rtl/core/sfa_queue.sv */
// Two-entry command queue between front and back.
`default_nettype none
module sfa_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output      logic          push_ready_o,
  input  wire sfa_pkg::cmd_t push_cmd_i,
  output      logic          pop_valid_o,
  input  wire logic          pop_i,
  output      sfa_pkg::cmd_t pop_cmd_o
);
  import sfa_pkg::*;

  cmd_t       ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_cmd_o    = ent_q[rp_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wp_q] <= push_cmd_i;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/sfa_back.sv */
// Back end: executes commands against the cell RAM and fragment bookkeeping.
`default_nettype none
module sfa_back #(
  parameter int unsigned MAX_FRAGMENTS      = 64,
  parameter int unsigned MAX_FRAGMENT_CELLS = 64,
  parameter int unsigned DATA_WIDTH         = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          pop_valid_i,
  output      logic          pop_o,
  input  wire sfa_pkg::cmd_t pop_cmd_i,
  input  wire logic [6:0]    nf_i,
  input  wire logic [6:0]    nc_i,
  input  wire logic [31:0]   marker_i,
  output      logic          out_valid_o,
  input  wire logic          out_stall_i,
  output      sfa_pkg::out_t out_o
);
  import sfa_pkg::*;

  localparam int unsigned FW = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
  localparam int unsigned CW = (MAX_FRAGMENT_CELLS > 1) ? $clog2(MAX_FRAGMENT_CELLS) : 1;
  localparam int unsigned AW = FW + CW;
  localparam int unsigned DW = DATA_WIDTH;

  typedef enum logic [6:0] {
    B_IDLE  = 7'b0000001,
    B_EXEC  = 7'b0000010,
    B_FILL  = 7'b0000100,
    B_SETW  = 7'b0001000,
    B_RMW   = 7'b0010000,
    B_SCAN  = 7'b0100000,
    B_DONE  = 7'b1000000
  } bstate_e;

  bstate_e            state_q, state_d;
  cmd_t               cmd_q, cmd_d;
  logic               act_q [MAX_FRAGMENTS];
  logic               act_d [MAX_FRAGMENTS];
  logic [IdxW-1:0]    total_q, total_d;
  logic [6:0]         live_q, live_d;
  logic [CW-1:0]      fcnt_q, fcnt_d;
  logic [FW-1:0]      sf_q, sf_d;
  logic [CW-1:0]      so_q, so_d;
  logic               pend_q, pend_d;
  logic               last_q, last_d;
  logic               found_q, found_d;
  status_e            st_q, st_d;
  logic [31:0]        rd_q, rd_d;
  logic               ov_q, ov_d;
  out_t               out_q, out_d;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [DW-1:0]      wdata, rdata;
  logic               fill_we;
  logic [6:0]         fill_wdata, fill_rdata;
  logic [FW-1:0]      frag;
  logic [CW-1:0]      off;
  logic [DW-1:0]      key_dw, mark_dw;
  logic [6:0]         fnew;
  logic               seg_end;

  assign frag    = cmd_q.frag[FW-1:0];
  assign off     = CW'(cmd_q.off);
  assign key_dw  = DW'($signed(cmd_q.key));
  assign mark_dw = DW'($signed(marker_i));

  assign out_valid_o = ov_q;
  assign out_o       = out_q;

  sfa_ram #(
    .WIDTH (DW),
    .DEPTH (2 ** AW)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // per-fragment fill counts; only read for active fragments, and
  // activation writes the first count, so no clearing is needed
  sfa_ram #(
    .WIDTH (7),
    .DEPTH (2 ** FW)
  ) u_fill (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (frag),
    .wdata_i (fill_wdata),
    .raddr_i (frag),
    .rdata_o (fill_rdata)
  );

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    act_d      = act_q;
    total_d    = total_q;
    live_d     = live_q;
    fcnt_d     = fcnt_q;
    sf_d       = sf_q;
    so_d       = so_q;
    pend_d     = 1'b0;
    last_d     = 1'b0;
    found_d    = found_q;
    st_d       = st_q;
    rd_d       = rd_q;
    ov_d       = ov_q && out_stall_i;
    out_d      = out_q;
    pop_o      = 1'b0;
    we         = 1'b0;
    waddr      = {frag, off};
    wdata      = key_dw;
    raddr      = {frag, off};
    fill_we    = 1'b0;
    fill_wdata = '0;
    fnew       = '0;
    seg_end    = 1'b0;

    case (state_q)
      B_IDLE: begin
        if (pop_valid_i) begin
          pop_o   = 1'b1;
          cmd_d   = pop_cmd_i;
          state_d = B_EXEC;
        end
      end
      B_EXEC: begin
        st_d    = ST_OK;
        rd_d    = '0;
        found_d = 1'b0;
        state_d = B_DONE;
        case (cmd_q.op)
          OP_SET: begin
            if (!cmd_q.idx_ok) begin
              st_d = ST_BAD_IDX;
            end else if (!act_q[frag]) begin
              act_d[frag] = 1'b1;
              live_d      = live_q + 7'd1;
              fcnt_d      = '0;
              state_d     = B_FILL;
            end else begin
              state_d = B_RMW;
            end
          end
          OP_GET: begin
            if (!cmd_q.idx_ok) begin
              st_d = ST_BAD_IDX;
            end else if (!act_q[frag]) begin
              rd_d = 32'(mark_dw);
            end else begin
              state_d = B_RMW;
            end
          end
          OP_DEL: begin
            if (!cmd_q.idx_ok) begin
              st_d = ST_BAD_IDX;
            end else if (!act_q[frag]) begin
              st_d = ST_NO_DEL;
            end else begin
              state_d = B_RMW;
            end
          end
          OP_HAS: begin
            if (nc_i != 7'd0 && nf_i != 7'd0) begin
              sf_d    = '0;
              so_d    = '0;
              state_d = B_SCAN;
            end
          end
          OP_CLR: begin
            for (int i = 0; i < MAX_FRAGMENTS; i++) begin
              act_d[i] = 1'b0;
            end
            total_d = '0;
            live_d  = '0;
          end
          default: ;
        endcase
      end
      B_FILL: begin
        we    = 1'b1;
        waddr = {frag, fcnt_q};
        wdata = mark_dw;
        fcnt_d = fcnt_q + 1'b1;
        if (32'(fcnt_q) == 32'(nc_i) - 32'd1) begin
          state_d = B_SETW;
        end
      end
      B_SETW: begin
        // freshly filled cell always counts as a new use; fill was zero
        we         = 1'b1;
        fill_we    = 1'b1;
        fill_wdata = 7'd1;
        if (total_q != 13'h1FFF)        total_d = total_q + 13'd1;
        state_d = B_DONE;
      end
      B_RMW: begin
        state_d = B_DONE;
        case (cmd_q.op)
          OP_SET: begin
            we = 1'b1;
            if (rdata == mark_dw) begin
              if (fill_rdata != 7'd127) begin
                fill_we    = 1'b1;
                fill_wdata = fill_rdata + 7'd1;
              end
              if (total_q != 13'h1FFF)    total_d = total_q + 13'd1;
            end
          end
          OP_GET: rd_d = 32'(rdata);
          OP_DEL: begin
            if (rdata == mark_dw) begin
              st_d = ST_NO_DEL;
            end else begin
              we    = 1'b1;
              wdata = mark_dw;
              if (total_q != '0) total_d = total_q - 13'd1;
              fnew = (fill_rdata != '0) ? fill_rdata - 7'd1 : '0;
              fill_we    = 1'b1;
              fill_wdata = fnew;
              if (fnew == '0) begin
                act_d[frag] = 1'b0;
                if (live_q != '0) live_d = live_q - 7'd1;
              end
            end
          end
          default: ;
        endcase
      end
      B_SCAN: begin
        // read for the current cell is issued here and compared in the next cycle
        if (pend_q && rdata == key_dw) found_d = 1'b1;
        if (last_q) begin
          state_d = B_DONE;
        end else begin
          raddr = {sf_q, so_q};
          if (act_q[sf_q]) begin
            pend_d  = 1'b1;
            seg_end = (32'(so_q) == 32'(nc_i) - 32'd1);
          end else begin
            if (mark_dw == key_dw) found_d = 1'b1;
            seg_end = 1'b1;
          end
          if (seg_end) begin
            so_d = '0;
            sf_d = sf_q + 1'b1;
            if (32'(sf_q) == 32'(nf_i) - 32'd1) last_d = 1'b1;
          end else begin
            so_d = so_q + 1'b1;
          end
        end
      end
      B_DONE: begin
        if (!ov_q || !out_stall_i) begin
          ov_d                 = 1'b1;
          out_d.status         = st_q;
          out_d.read_value     = rd_q;
          out_d.key_found      = found_q;
          out_d.used_cells     = total_q;
          out_d.live_fragments = live_q;
          state_d              = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      for (int i = 0; i < MAX_FRAGMENTS; i++) begin
        act_q[i] <= 1'b0;
      end
      total_q <= '0;
      live_q  <= '0;
      pend_q  <= 1'b0;
      last_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
      total_q <= total_d;
      live_q  <= live_d;
      pend_q  <= pend_d;
      last_q  <= last_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    fcnt_q  <= fcnt_d;
    sf_q    <= sf_d;
    so_q    <= so_d;
    found_q <= found_d;
    st_q    <= st_d;
    rd_q    <= rd_d;
    out_q   <= out_d;
  end

endmodule
`default_nettype wire

/* rtl/core/sparse_fragmented_array_table.sv */
// Top level of the sparse fragmented array table.
`default_nettype none
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------
//  in      | in        | in_valid_i / in_stall_o   | sfa_pkg::in_t
//  out     | out       | out_valid_o / out_stall_i | sfa_pkg::out_t
//  cfg     | in        | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
//  Front: takes a transaction, runs the serial index division on valid
//  set/get/delete, then hands it to the 2-deep queue.
//  Back: get/delete/set on an active fragment step through pop, read,
//  modify-write and result; set on an inactive fragment adds one write
//  per cell of the fragment; contains reads every cell of each active
//  fragment and compares the marker once for each inactive fragment.
//  The single cell RAM port pair sets the back-end pace. Reset needs no
//  clearing pass: the cell store and the fill counts are only read for
//  fragments that were activated (and so written) first.
//  Out stall holds the result register; the back then waits, the queue
//  fills and the front stalls the input.
//
module sparse_fragmented_array_table #(
  parameter int unsigned MAX_FRAGMENTS      = 64,
  parameter int unsigned MAX_FRAGMENT_CELLS = 64,
  parameter int unsigned DATA_WIDTH         = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire sfa_pkg::in_t                in_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      sfa_pkg::out_t               out_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [1:0]                  cfg_idx_i,
  input  wire logic [sfa_pkg::CfgW-1:0]    cfg_data_i
);
  import sfa_pkg::*;

  localparam int unsigned MaxF = MAX_FRAGMENTS;
  localparam int unsigned MaxC = MAX_FRAGMENT_CELLS;

  logic [6:0]  frags_q, cells_q;
  logic [31:0] marker_q;
  logic [6:0]  nf, nc;

  logic        push_valid, push_ready, pop_valid, pop;
  cmd_t        push_cmd, pop_cmd;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frags_q  <= 7'd64;
      cells_q  <= 7'd64;
      marker_q <= 32'hFFFF_FFFF;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        CFG_FRAGS:  frags_q  <= cfg_data_i[6:0];
        CFG_CELLS:  cells_q  <= cfg_data_i[6:0];
        CFG_MARKER: marker_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // oversized settings saturate to the built-in maxima
  assign nf = (32'(frags_q) > MaxF) ? 7'(MaxF) : frags_q;
  assign nc = (32'(cells_q) > MaxC) ? 7'(MaxC) : cells_q;

  sfa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_i         (in_i),
    .nf_i         (nf),
    .nc_i         (nc),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  sfa_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_cmd_o    (pop_cmd)
  );

  sfa_back #(
    .MAX_FRAGMENTS      (MAX_FRAGMENTS),
    .MAX_FRAGMENT_CELLS (MAX_FRAGMENT_CELLS),
    .DATA_WIDTH         (DATA_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .pop_cmd_i   (pop_cmd),
    .nf_i        (nf),
    .nc_i        (nc),
    .marker_i    (marker_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire

/* bench/sfa_checker.sv */
// Checker for the sparse fragmented array table: predicts and compares results.
`timescale 1ns / 100ps
module sfa_checker (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_stall_i,
  input  wire sfa_pkg::in_t  in_i,
  input  wire logic          out_valid_i,
  input  wire logic          out_stall_i,
  input  wire sfa_pkg::out_t out_i,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_idx_i,
  input  wire logic [31:0]   cfg_data_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 results_o
);
  import sfa_pkg::*;

  logic [31:0] cells [64*64];
  logic        active [64];
  int unsigned fill [64];
  int unsigned used_total, live_total;
  int unsigned n_frags, n_cells;
  logic [31:0] marker;
  out_t        expected_q [$];

  function automatic logic [31:0] peek(int unsigned f, int unsigned o);
    return active[f] ? cells[f*64+o] : marker;
  endfunction

  function automatic out_t table_op(in_t t);
    out_t r;
    int unsigned nf, nc, cap, idx, f, o;
    logic ok;
    r = '0;
    nf = (n_frags > 64) ? 64 : n_frags;
    nc = (n_cells > 64) ? 64 : n_cells;
    cap = nf * nc;
    idx = t.cell_index;
    ok = (nc != 0) && (idx < cap);
    f = ok ? idx / nc : 0;
    o = ok ? idx % nc : 0;
    case (t.opcode)
      OP_SET: if (!ok) r.status = ST_BAD_IDX;
      else begin
        if (!active[f]) begin
          active[f] = 1'b1;
          for (int i = 0; i < nc; i++) cells[f*64+i] = marker;
          live_total++;
        end
        if (cells[f*64+o] == marker) begin
          if (fill[f] < 127) fill[f]++;
          if (used_total < 8191) used_total++;
        end
        cells[f*64+o] = t.key_value;
      end
      OP_GET: if (!ok) r.status = ST_BAD_IDX;
      else r.read_value = peek(f, o);
      OP_DEL: if (!ok) r.status = ST_BAD_IDX;
      else if (!active[f] || cells[f*64+o] == marker) r.status = ST_NO_DEL;
      else begin
        cells[f*64+o] = marker;
        if (used_total > 0) used_total--;
        if (fill[f] > 0) fill[f]--;
        if (fill[f] == 0) begin
          active[f] = 1'b0;
          if (live_total > 0) live_total--;
        end
      end
      OP_HAS: for (int i = 0; i < cap; i++)
        if (peek(i / nc, i % nc) == t.key_value) r.key_found = 1'b1;
      OP_CLR: begin
        for (int i = 0; i < 64; i++) begin
          active[i] = 1'b0;
          fill[i] = 0;
        end
        used_total = 0;
        live_total = 0;
      end
      default: ;
    endcase
    r.used_cells = used_total[12:0];
    r.live_fragments = live_total[6:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 64; i++) begin
        active[i] = 1'b0;
        fill[i] = 0;
      end
      used_total = 0;
      live_total = 0;
      n_frags = 64;
      n_cells = 64;
      marker = 32'hFFFF_FFFF;
      errors_o = 0;
      results_o = 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FRAGS:  n_frags = cfg_data_i[6:0];
          CFG_CELLS:  n_cells = cfg_data_i[6:0];
          CFG_MARKER: marker = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(table_op(in_i));
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (expected_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected result %p", $time, out_i);
        end else begin
          want = expected_q.pop_front();
          if (want !== out_i) begin
            errors_o++;
            $display("%0t: mismatch expected %p actual %p", $time, want, out_i);
          end
        end
      end
    end
    pending_o = expected_q.size();
  end
endmodule

/* bench/sparse_fragmented_array_table_test.sv */
// Stimulus and verdict for the sparse fragmented array table.
`timescale 1ns / 100ps
module sparse_fragmented_array_table_test;
  import sfa_pkg::*;

  logic        clk, rst_n;
  logic        in_valid, in_stall, out_valid, out_stall;
  in_t         in_item;
  out_t        out_item;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_data;
  int          errors, pending, results;
  int          send_idle, recv_stall;   // percent chances of a gap
  logic        hold_off;                // long receiver stall for pressure
  int unsigned capacity;
  logic [31:0] marker;
  logic [31:0] keys [16];               // small key pool so hits happen

  sparse_fragmented_array_table uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_o(out_item),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  sfa_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_i(in_item),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_i(out_item),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: random stalls per phase, or a long hold-off when asked.
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_stall);
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  // Offer one transaction; holds valid until it is taken. Valid stays up
  // afterwards until the next send or a drain takes it down.
  task automatic send(op_e op, logic [12:0] idx, logic [31:0] key);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{opcode: op, cell_index: idx, key_value: key};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // set can still be filling a fragment; let it finish
    repeat (80) @(posedge clk);
  endtask

  task automatic configure(int unsigned frags, int unsigned cells, logic [31:0] mark);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_FRAGS;
    cfg_data <= frags;
    @(posedge clk);
    cfg_idx <= CFG_CELLS;
    cfg_data <= cells;
    @(posedge clk);
    cfg_idx <= CFG_MARKER;
    cfg_data <= mark;
    @(posedge clk);
    cfg_we <= 1'b0;
    capacity = (frags > 64 ? 64 : frags) * (cells > 64 ? 64 : cells);
    marker = mark;
  endtask

  // Mostly in-range indexes and pooled keys, some wild ones.
  task automatic random_op();
    int unsigned pick;
    logic [12:0] idx;
    logic [31:0] key;
    pick = $urandom_range(99);
    if (capacity != 0 && $urandom_range(9) != 0) idx = 13'($urandom_range(capacity - 1));
    else idx = 13'($urandom);
    if ($urandom_range(9) == 0) key = marker;
    else if ($urandom_range(3) == 0) key = $urandom;
    else key = keys[$urandom_range(15)];
    if (pick < 40) send(OP_SET, idx, key);
    else if (pick < 60) send(OP_GET, idx, key);
    else if (pick < 82) send(OP_DEL, idx, key);
    else if (pick < 95) send(OP_HAS, idx, key);
    else if (pick < 97) send(OP_CLR, idx, key);
    else send(op_e'(3'($urandom_range(7, 5))), idx, key);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_FRAGS;
    cfg_data = '0;
    send_idle = 0;
    recv_stall = 0;
    hold_off = 1'b0;
    capacity = 4096;
    marker = 32'hFFFF_FFFF;
    for (int i = 0; i < 16; i++) keys[i] = $urandom;
    keys[0] = 32'h0000_0000;
    keys[1] = 32'h8000_0000;
    keys[2] = 32'h7FFF_FFFF;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset config, field extremes, every opcode.
    send(OP_GET, 13'd0, '0);             // inactive fragment reads the marker
    send(OP_DEL, 13'd0, '0);             // nothing to delete
    send(OP_SET, 13'd0, 32'h8000_0000);
    send(OP_SET, 13'd4095, 32'h7FFF_FFFF);
    send(OP_SET, 13'd4095, 32'h1234_5678); // overwrite, no new use
    send(OP_SET, 13'd1, 32'hFFFF_FFFF);  // storing the marker counts as a use
    send(OP_GET, 13'd0, '0);
    send(OP_GET, 13'd4095, '0);
    send(OP_SET, 13'd4096, 32'h1);       // invalid index
    send(OP_GET, 13'd8191, '0);
    send(OP_DEL, 13'd8191, '0);
    send(OP_HAS, 13'd0, 32'h8000_0000);
    send(OP_HAS, 13'd0, 32'h5555_5555);
    send(OP_HAS, 13'd0, 32'hFFFF_FFFF);
    send(OP_DEL, 13'd4095, '0);          // empties the last fragment
    send(OP_DEL, 13'd1, '0);             // marker valued cell: nothing to delete
    send(op_e'(3'd7), 13'h1555, 32'h5A5A_5A5A);
    send(op_e'(3'd5), 13'h0AAA, 32'hA5A5_A5A5);
    send(OP_CLR, 13'd0, '0);
    send(OP_GET, 13'd0, '0);

    // Zero capacity and oversized registers.
    configure(0, 8, 32'd0);
    send(OP_SET, 13'd0, 32'd5);
    send(OP_HAS, 13'd0, 32'd0);
    configure(5, 0, 32'd0);
    send(OP_GET, 13'd0, 32'd5);
    send(OP_HAS, 13'd0, 32'd0);
    configure(127, 127, 32'h7FFF_FFFF);
    send(OP_SET, 13'd4095, 32'd9);
    send(OP_GET, 13'd4095, 32'd0);
    send(OP_CLR, 13'd0, 32'd0);

    // Random phases over several table shapes and idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 63; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 63; end
        default: begin send_idle = 20; recv_stall = 20; end
      endcase
      case (ph)
        0: configure(4, 4, 32'hFFFF_FFFF);
        1: configure(1, 1, 32'h8000_0000);
        2: configure(3, 7, 32'd0);
        3: configure(64, 1, 32'h7FFF_FFFF);
        4: configure(1, 64, $urandom);
        5: configure(8, 3, 32'hFFFF_FFFF);
        6: configure(2, 5, keys[3]);
        default: configure(64, 64, 32'hFFFF_FFFF);
      endcase
      send(OP_CLR, 13'd0, '0);
      for (int n = 0; n < 110; n++) random_op();
    end

    // Pressure: receiver holds off while the sender keeps offering.
    send_idle = 0;
    recv_stall = 0;
    configure(4, 4, 32'hFFFF_FFFF);
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int n = 0; n < 30; n++) random_op();
    join

    drain();
    $display("Covered %0d results over many table shapes, markers and idling patterns,",
             results);
    $display("including zero capacity, oversized registers and a long output hold-off.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/core/sfa_pkg.sv
rtl/core/sfa_ram.sv
rtl/core/sfa_front.sv
rtl/core/sfa_queue.sv
rtl/core/sfa_back.sv
rtl/core/sparse_fragmented_array_table.sv
bench/sfa_checker.sv
bench/sparse_fragmented_array_table_test.sv
